@@ rtl/core/aes_ctr_pkg.sv @@
// ----------------------------------------------------------------------------
// AES-256 CTR package
// Shared types, constants and round functions of the counter-mode keystream.
// ----------------------------------------------------------------------------
package aes_ctr_pkg;

  localparam int unsigned NumRounds = 14;

  typedef enum logic [6:0] {
    RegKey0   = 7'd0,
    RegKey1   = 7'd1,
    RegKey2   = 7'd2,
    RegKey3   = 7'd3,
    RegIvUp   = 7'd4,
    RegIvLo   = 7'd5,
    RegIvLen  = 7'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StInit,
    StRound,
    StOut
  } ctrl_state_e;

  typedef struct packed {
    logic init;
    logic round;
    logic load_ks;
    logic take;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic       cache_empty;
    logic       last_round;
  } dp_sts_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a 128-bit block sits in bits [127-8i -: 8].
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic mix);
    logic [7:0]   b [16];
    logic [7:0]   t [16];
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = sbox(s[127 - 8 * i -: 8]);
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) t[i + 4 * c] = b[i + 4 * ((c + i) % 4)];
    end
    for (int c = 0; c < 4; c++) begin
      if (mix) begin
        r[127 - 8 * (4 * c) -: 8] = xt(t[4*c]) ^ xt(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
        r[127 - 8 * (4 * c + 1) -: 8] = t[4*c] ^ xt(t[4*c+1]) ^ xt(t[4*c+2]) ^ t[4*c+2] ^
                                        t[4*c+3];
        r[127 - 8 * (4 * c + 2) -: 8] = t[4*c] ^ t[4*c+1] ^ xt(t[4*c+2]) ^ xt(t[4*c+3]) ^
                                        t[4*c+3];
        r[127 - 8 * (4 * c + 3) -: 8] = xt(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^
                                        xt(t[4*c+3]);
      end else begin
        for (int i = 0; i < 4; i++) r[127 - 8 * (4 * c + i) -: 8] = t[4 * c + i];
      end
    end
    return r;
  endfunction

  // Eight key-schedule words from the previous eight; the caller passes rcon in rc.
  function automatic logic [255:0] key_step(input logic [255:0] k, input logic [7:0] rc);
    logic [31:0] w [8];
    logic [31:0] t;
    logic [255:0] r;
    for (int i = 0; i < 8; i++) w[i] = k[255 - 32 * i -: 32];
    t = w[7];
    t = {sbox(t[23:16]) ^ rc, sbox(t[15:8]), sbox(t[7:0]), sbox(t[31:24])};
    w[0] = w[0] ^ t;
    for (int i = 1; i < 4; i++) w[i] = w[i] ^ w[i - 1];
    t = w[3];
    t = {sbox(t[31:24]), sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0])};
    w[4] = w[4] ^ t;
    for (int i = 5; i < 8; i++) w[i] = w[i] ^ w[i - 1];
    for (int i = 0; i < 8; i++) r[255 - 32 * i -: 32] = w[i];
    return r;
  endfunction

endpackage

@@ rtl/core/aes_ctr_ctrl.sv @@
// ----------------------------------------------------------------------------
// AES-256 CTR controller
// Sequences keystream refills and byte transfers.
// ----------------------------------------------------------------------------
module aes_ctr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_free_i,
  input  logic                 cfg_we_i,
  input  aes_ctr_pkg::dp_sts_t sts_i,
  output logic                 in_ready_o,
  output aes_ctr_pkg::dp_cmd_t cmd_o
);

  aes_ctr_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aes_ctr_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      aes_ctr_pkg::StIdle: begin
        if (in_valid_i && !cfg_we_i) begin
          if (sts_i.cache_empty) begin
            cmd_o.init = 1'b1;
            state_d    = aes_ctr_pkg::StRound;
          end else if (out_free_i) begin
            in_ready_o = 1'b1;
            cmd_o.take = 1'b1;
          end
        end
      end
      aes_ctr_pkg::StRound: begin
        cmd_o.round = 1'b1;
        if (sts_i.last_round) begin
          cmd_o.load_ks = 1'b1;
          state_d       = aes_ctr_pkg::StIdle;
        end
      end
      default: state_d = aes_ctr_pkg::StIdle;
    endcase
  end

endmodule

@@ rtl/core/aes_ctr_dp.sv @@
// ----------------------------------------------------------------------------
// AES-256 CTR datapath
// Config registers, counter, one-round-per-cycle AES core and byte cache.
// ----------------------------------------------------------------------------
module aes_ctr_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [6:0]           cfg_addr_i,
  input  logic [63:0]          cfg_wdata_i,
  input  aes_ctr_pkg::dp_cmd_t cmd_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_in_i,
  input  logic                 out_ready_i,
  output aes_ctr_pkg::dp_sts_t sts_o,
  output logic                 out_free_o,
  output logic                 out_valid_o,
  output logic [7:0]           out_byte_o,
  output logic                 last_out_o
);

  logic [255:0] key_q;
  logic [127:0] iv_q;
  logic [4:0]   iv_len_q;
  logic [127:0] ctr_q, ctr_d;
  logic [127:0] ks_q;
  logic [127:0] st_q;
  logic [255:0] rk_q;
  logic [3:0]   rnd_q;
  logic [4:0]   rem_q;
  logic         ov_q;
  logic [7:0]   ob_q;
  logic         ol_q;
  logic [255:0] key_nx;
  logic [7:0]   rc;
  logic [127:0] rnd_key;
  logic [127:0] rnd_out;
  logic [255:0] key_d;
  logic [127:0] iv_d;
  logic [4:0]   len_d;
  logic [3:0]   idx;

  always_comb begin
    key_d = key_q;
    iv_d  = iv_q;
    len_d = iv_len_q;
    case (cfg_addr_i)
      aes_ctr_pkg::RegKey0:  key_d[255:192] = cfg_wdata_i;
      aes_ctr_pkg::RegKey1:  key_d[191:128] = cfg_wdata_i;
      aes_ctr_pkg::RegKey2:  key_d[127:64]  = cfg_wdata_i;
      aes_ctr_pkg::RegKey3:  key_d[63:0]    = cfg_wdata_i;
      aes_ctr_pkg::RegIvUp:  iv_d[127:64]   = cfg_wdata_i;
      aes_ctr_pkg::RegIvLo:  iv_d[63:0]     = cfg_wdata_i;
      aes_ctr_pkg::RegIvLen: len_d          = cfg_wdata_i[4:0];
      default: ;
    endcase
    for (int i = 0; i < 16; i++) begin
      ctr_d[127 - 8 * i -: 8] = (i < 32'(len_d)) ? iv_d[127 - 8 * i -: 8] : 8'h00;
    end
  end

  // Round keys: rnd_q odd uses the lower half, even pulls a new eight-word step.
  always_comb begin
    rc = 8'h01 << (rnd_q[3:1] - 3'd1);
    key_nx = aes_ctr_pkg::key_step(rk_q, rc);
    rnd_key = rnd_q[0] ? rk_q[127:0] : key_nx[255:128];
    rnd_out = aes_ctr_pkg::enc_round(st_q, rnd_q != 4'(aes_ctr_pkg::NumRounds)) ^ rnd_key;
    idx = 4'(5'd16 - rem_q);
  end

  assign sts_o.cache_empty = (rem_q == 5'd0);
  assign sts_o.last_round  = (rnd_q == 4'(aes_ctr_pkg::NumRounds));
  assign out_free_o  = !ov_q || out_ready_i;
  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign last_out_o  = ol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q    <= '0;
      iv_q     <= '0;
      iv_len_q <= '0;
      ctr_q    <= '0;
      rem_q    <= '0;
      ov_q     <= 1'b0;
      rnd_q    <= '0;
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      if (cfg_we_i) begin
        key_q    <= key_d;
        iv_q     <= iv_d;
        iv_len_q <= len_d;
        if (cfg_addr_i <= aes_ctr_pkg::RegIvLen) begin
          ctr_q <= ctr_d;
          rem_q <= '0;
        end
      end else if (cmd_i.init) begin
        rnd_q <= 4'd1;
      end else if (cmd_i.round) begin
        rnd_q <= rnd_q + 4'd1;
        if (cmd_i.load_ks) rem_q <= 5'd16;
      end else if (cmd_i.take) begin
        ov_q  <= 1'b1;
        rem_q <= rem_q - 5'd1;
        if (rem_q == 5'd1) ctr_q <= ctr_q + 128'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      st_q <= ctr_q ^ key_q[255:128];
      rk_q <= key_q;
    end else if (cmd_i.round) begin
      st_q <= rnd_out;
      if (!rnd_q[0]) rk_q <= key_nx;
      if (cmd_i.load_ks) ks_q <= rnd_out;
    end
    if (cmd_i.take) begin
      ob_q <= data_byte_i ^ ks_q[127 - 8 * idx -: 8];
      ol_q <= last_in_i;
    end
  end

endmodule

@@ rtl/core/aes256_ctr_keystream_xor.sv @@
// ----------------------------------------------------------------------------
// AES-256 CTR keystream XOR
// Transforms one byte per transfer with a cached AES-256 counter keystream.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         tdata = data_byte, tlast = last_in
// m_axis    out        tdata = out_byte, tlast = last_out
// cfg       in         cfg_we_i, cfg_addr_i, cfg_wdata_i
// A cached byte is XORed straight from the cache; every sixteenth byte first
// costs a refill of an init step and the rounds of the single shared round unit.
// A byte enters only while the output register is empty or its result
// transfers in the same cycle, so a stalled result holds the input.
// Reset empties the cache and loads a zero counter; no clearing pass is needed.
// ----------------------------------------------------------------------------
module aes256_ctr_keystream_xor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_addr_i,
  input  logic [63:0] cfg_wdata_i
);

  aes_ctr_pkg::dp_cmd_t cmd;
  aes_ctr_pkg::dp_sts_t sts;
  logic                 out_free;

  aes_ctr_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .out_free_i (out_free),
    .cfg_we_i,
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  aes_ctr_dp u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .cmd_i       (cmd),
    .data_byte_i (s_axis_tdata),
    .last_in_i   (s_axis_tlast),
    .out_ready_i (m_axis_tready),
    .sts_o       (sts),
    .out_free_o  (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_byte_o  (m_axis_tdata),
    .last_out_o  (m_axis_tlast)
  );

  a_accept_has_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> !sts.cache_empty)
    else $error("byte accepted with an empty keystream cache");
  a_accept_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted byte produced no result");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("result overwritten while stalled");

endmodule

@@ test/aes256_ctr_keystream_xor_tb.sv @@
// ----------------------------------------------------------------------------
// AES-256 CTR keystream XOR testbench
// Streams bytes through the block under several key and IV settings and
// checks every output transfer against a cycle-free AES-256 CTR predictor.
// ----------------------------------------------------------------------------
module aes256_ctr_keystream_xor_tb;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } xfer_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       chk;
    logic [7:0] want;
  } vec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [6:0]  cfg_addr_i = '0;
  logic [63:0] cfg_wdata_i = '0;

  logic [63:0]  key_w [4];
  logic [63:0]  ivu, ivl;
  logic [4:0]   ivlen;
  logic [127:0] ctr, ks;
  int           ks_left;
  xfer_t        pending_q [$];
  int           errors = 0;
  int           cycles = 0;
  int           send_idle = 0;
  int           recv_idle = 0;

  aes256_ctr_keystream_xor dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] sub(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of every block is held in element i, byte 0 first.
  function automatic logic [127:0] aes256_encrypt(input logic [127:0] blk);
    logic [7:0] rk [240];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] w [4];
    logic [7:0] f, a0, a1, a2, a3;
    logic [7:0] rc [8];
    logic [127:0] r;
    rc = '{8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40};
    for (int i = 0; i < 32; i++) rk[i] = key_w[i / 8][63 - 8 * (i % 8) -: 8];
    for (int i = 8; i < 60; i++) begin
      for (int k = 0; k < 4; k++) w[k] = rk[4 * (i - 1) + k];
      if (i % 8 == 0) begin
        f = w[0];
        w[0] = sub(w[1]) ^ rc[(i / 8) % 8];
        w[1] = sub(w[2]);
        w[2] = sub(w[3]);
        w[3] = sub(f);
      end else if (i % 8 == 4) begin
        for (int k = 0; k < 4; k++) w[k] = sub(w[k]);
      end
      for (int k = 0; k < 4; k++) rk[4 * i + k] = rk[4 * (i - 8) + k] ^ w[k];
    end
    for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8] ^ rk[i];
    for (int rn = 1; rn <= 14; rn++) begin
      for (int i = 0; i < 16; i++) s[i] = sub(s[i]);
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[i + 4 * c] = s[i + 4 * ((c + i) % 4)];
      for (int c = 0; c < 4; c++) begin
        a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
        if (rn != 14) begin
          s[4 * c]     = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
          s[4 * c + 1] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
          s[4 * c + 2] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
          s[4 * c + 3] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
        end else begin
          s[4 * c] = a0; s[4 * c + 1] = a1; s[4 * c + 2] = a2; s[4 * c + 3] = a3;
        end
      end
      for (int i = 0; i < 16; i++) s[i] = s[i] ^ rk[16 * rn + i];
    end
    for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = s[i];
    return r;
  endfunction

  function automatic void reload_counter();
    int n;
    logic [127:0] iv;
    n = (ivlen > 16) ? 16 : ivlen;
    iv = {ivu, ivl};
    for (int i = 0; i < 16; i++)
      ctr[127 - 8 * i -: 8] = (i < n) ? iv[127 - 8 * i -: 8] : 8'h00;
    ks_left = 0;
  endfunction

  function automatic xfer_t keystream_xor(input xfer_t x);
    xfer_t r;
    if (ks_left == 0) begin
      ks = aes256_encrypt(ctr);
      ks_left = 16;
    end
    r.data = x.data ^ ks[127 - 8 * (16 - ks_left) -: 8];
    r.last = x.last;
    ks_left--;
    if (ks_left == 0) ctr = ctr + 128'd1;
    return r;
  endfunction

  task automatic write_reg(input logic [6:0] idx, input logic [63:0] val);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      aes_ctr_pkg::RegKey0, aes_ctr_pkg::RegKey1,
      aes_ctr_pkg::RegKey2, aes_ctr_pkg::RegKey3: key_w[idx[1:0]] = val;
      aes_ctr_pkg::RegIvUp:  ivu = val;
      aes_ctr_pkg::RegIvLo:  ivl = val;
      aes_ctr_pkg::RegIvLen: ivlen = val[4:0];
      default:  return;
    endcase
    reload_counter();
  endtask

  task automatic drive_byte(input logic [7:0] d, input logic l, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    s_axis_tlast <= l;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_byte(input logic [7:0] d, input logic l, input int idle_pct);
    pending_q.push_back(keystream_xor('{data: d, last: l}));
    drive_byte(d, l, idle_pct);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_q.size() == 0) begin
          $error("unexpected transfer out_byte=%h", m_axis_tdata);
          errors++;
        end else begin
          if (m_axis_tdata !== pending_q[0].data) begin
            $error("out_byte expected %h actual %h", pending_q[0].data, m_axis_tdata);
            errors++;
          end
          if (m_axis_tlast !== pending_q[0].last) begin
            $error("last_out expected %b actual %b", pending_q[0].last, m_axis_tlast);
            errors++;
          end
          void'(pending_q.pop_front());
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  vec_t dir_tab [] = '{
    '{8'h00, 1'b0, 1'b1, 8'hdc},
    '{8'hff, 1'b1, 1'b0, 8'h00},
    '{8'h55, 1'b0, 1'b0, 8'h00},
    '{8'haa, 1'b1, 1'b0, 8'h00}
  };

  initial begin
    int pct [4][2] = '{'{0, 0}, '{68, 0}, '{0, 68}, '{37, 37}};
    int phase;
    for (int k = 0; k < 4; k++) key_w[k] = '0;
    ivu = '0; ivl = '0; ivlen = '0;
    ks = '0;
    reload_counter();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero key and zero counter: first keystream byte of AES-256 is 0xdc.
    foreach (dir_tab[i]) begin
      if (dir_tab[i].chk) begin
        pending_q.push_back('{data: dir_tab[i].want, last: dir_tab[i].last});
        void'(keystream_xor('{data: dir_tab[i].data, last: dir_tab[i].last}));
        drive_byte(dir_tab[i].data, dir_tab[i].last, 0);
      end else begin
        send_byte(dir_tab[i].data, dir_tab[i].last, 0);
      end
    end
    for (int i = 0; i < 14; i++) send_byte(8'($urandom), 1'($urandom), 0);
    drain();

    // Counter wrap from all ones with the full IV and an oversize IV length.
    write_reg(aes_ctr_pkg::RegIvUp, '1);
    write_reg(aes_ctr_pkg::RegIvLo, '1);
    write_reg(aes_ctr_pkg::RegIvLen, 64'd31);
    write_reg(aes_ctr_pkg::RegKey3, '1);
    write_reg(7'd100, 64'h1234);
    for (int i = 0; i < 20; i++) send_byte(8'($urandom), 1'(i == 19), 0);
    drain();

    for (int p = 0; p < 12; p++) begin
      phase = p % 4;
      send_idle = pct[phase][0];
      recv_idle = pct[phase][1];
      drain();
      for (int k = 0; k < 4; k++)
        write_reg(aes_ctr_pkg::cfg_reg_e'(k), (p == 1) ? 64'h0 : {$urandom, $urandom});
      write_reg(aes_ctr_pkg::RegIvUp, {$urandom, $urandom});
      write_reg(aes_ctr_pkg::RegIvLo,
                (p == 2) ? 64'hffff_ffff_ffff_fff0 : {$urandom, $urandom});
      write_reg(aes_ctr_pkg::RegIvLen,
                (p == 3) ? 64'd0 : (p == 2) ? 64'd16 : 64'($urandom_range(31)));
      if ($urandom_range(3) == 0) write_reg(7'($urandom_range(127, 7)), {$urandom, $urandom});
      for (int i = 0; i < 115; i++) begin
        send_byte(8'($urandom), 1'($urandom_range(7) == 0), send_idle);
        if (i == 60 && p == 5) drain();
      end
    end
    recv_idle = 0;
    drain();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
